/* rtl/qtw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtw_pkg: shared types and constants of the quadtree node index walk
// Config register indices, controller command and datapath status words.
// ----------------------------------------------------------------------------
package qtw_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LEVEL1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LEVEL2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LEVEL3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_L4_WEST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_L4_EAST = 3'd4;

    localparam int LEVEL_W = 5;
    localparam int LAT_W = 16;
    localparam int LNG_W = 17;
    localparam int FIELD_W = 16;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // input word accepted this cycle
        logic res_direct;  // result comes from level 1..3 roots or invalid level
        logic res_root;    // result is the level-4 root
        logic res_child;   // result is the child selected this cycle
        logic walk_start;  // read table at level-4 root
        logic walk_step;   // read table at selected child
        logic push;        // move pending result to output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic direct;       // level 0, 1..3 or above max
        logic root_final;   // level 4 or level-4 root absent
        logic child_final;  // last level reached or child absent
        logic out_free;     // output register empty or drained this cycle
    } status_t;

endpackage

/* rtl/qtw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtw_ctrl: walk sequencer
// Accepts words, steps the tree walk one level per cycle, hands off results.
// ----------------------------------------------------------------------------
module qtw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_mode,
    output logic             s_ready,
    input  qtw_pkg::status_t status,
    output qtw_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_mode) begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                if (status.direct) begin
                    cmd.res_direct = 1'b1;
                    state_next = ST_DONE;
                end else if (status.root_final) begin
                    cmd.res_root = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.child_final) begin
                    cmd.res_child = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.push = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/qtw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtw_datapath: node table, root registers and walk datapath
// Table memory with registered read, bit selection per level, output register.
// ----------------------------------------------------------------------------
module qtw_datapath #(
    parameter int NODE_BITS = 16,
    parameter int MAX_LEVEL = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [qtw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qtw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_mode,
    input  logic [qtw_pkg::FIELD_W-1:0]         s_entry_index,
    input  logic [qtw_pkg::FIELD_W-1:0]         s_child_slot0,
    input  logic [qtw_pkg::FIELD_W-1:0]         s_child_slot1,
    input  logic [qtw_pkg::FIELD_W-1:0]         s_child_slot2,
    input  logic [qtw_pkg::FIELD_W-1:0]         s_child_slot3,
    input  logic [qtw_pkg::LEVEL_W-1:0]         s_level,
    input  logic [qtw_pkg::LAT_W-1:0]           s_lat_index,
    input  logic [qtw_pkg::LNG_W-1:0]           s_lng_index,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [qtw_pkg::FIELD_W-1:0]         m_node_index,
    output logic                                m_found,
    input  qtw_pkg::cmd_t                       cmd,
    output qtw_pkg::status_t                    status
);

    localparam int NB = NODE_BITS;
    localparam int DEPTH = 1 << NODE_BITS;
    localparam logic [NB-1:0] ABSENT = {NB{1'b1}};
    localparam logic [qtw_pkg::LEVEL_W-1:0] MAX_LVL = qtw_pkg::LEVEL_W'(MAX_LEVEL);
    localparam logic [qtw_pkg::LEVEL_W-1:0] LVL_ROOT4 = qtw_pkg::LEVEL_W'(4);
    localparam logic [qtw_pkg::LEVEL_W-1:0] LVL_ROOT3 = qtw_pkg::LEVEL_W'(3);
    localparam logic [qtw_pkg::LEVEL_W-1:0] LVL_FIRST_WALK = qtw_pkg::LEVEL_W'(5);

    // root registers
    logic [NB-1:0] root1_reg, root2_reg, root3_reg, root4w_reg, root4e_reg;
    logic [NB-1:0] cfg_val;

    assign cfg_val = NB'(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root1_reg  <= ABSENT;
            root2_reg  <= ABSENT;
            root3_reg  <= ABSENT;
            root4w_reg <= ABSENT;
            root4e_reg <= ABSENT;
        end else if (cfg_wen) begin
            case (cfg_index)
                qtw_pkg::CFG_ROOT_LEVEL1:  root1_reg  <= cfg_val;
                qtw_pkg::CFG_ROOT_LEVEL2:  root2_reg  <= cfg_val;
                qtw_pkg::CFG_ROOT_LEVEL3:  root3_reg  <= cfg_val;
                qtw_pkg::CFG_ROOT_L4_WEST: root4w_reg <= cfg_val;
                qtw_pkg::CFG_ROOT_L4_EAST: root4e_reg <= cfg_val;
                default: ;
            endcase
        end
    end

    // node table
    logic [4*NB-1:0] mem [0:DEPTH-1];
    logic [4*NB-1:0] rd_data_reg;
    logic [NB-1:0]   wr_addr;
    logic            wr_en;
    logic [NB-1:0]   rd_addr;
    logic            rd_en;

    assign wr_addr = NB'(s_entry_index);
    assign wr_en = cmd.capture && !s_mode && (wr_addr != ABSENT);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {NB'(s_child_slot3), NB'(s_child_slot2),
                             NB'(s_child_slot1), NB'(s_child_slot0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // captured lookup
    logic [qtw_pkg::LEVEL_W-1:0] lvl_reg;
    logic [qtw_pkg::LAT_W-1:0]   lat_reg;
    logic [qtw_pkg::LNG_W-1:0]   lng_reg;
    logic [qtw_pkg::LEVEL_W-1:0] sh_reg;   // bit position of the next step

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lvl_reg <= s_level;
            lat_reg <= s_lat_index;
            lng_reg <= s_lng_index;
        end
        if (cmd.walk_start) begin
            sh_reg <= lvl_reg - LVL_FIRST_WALK;
        end else if (cmd.walk_step) begin
            sh_reg <= sh_reg - qtw_pkg::LEVEL_W'(1);
        end
    end

    // level-4 root: longitude bit (level - 4)
    logic [qtw_pkg::LEVEL_W-1:0] half_pos;
    logic                        half_bit;
    logic [NB-1:0]               root4;
    logic [NB-1:0]               direct_val;

    assign half_pos = lvl_reg - LVL_ROOT4;
    assign half_bit = (half_pos < qtw_pkg::LEVEL_W'(qtw_pkg::LNG_W)) ? lng_reg[half_pos] : 1'b0;
    assign root4 = half_bit ? root4e_reg : root4w_reg;

    always_comb begin
        case (lvl_reg)
            qtw_pkg::LEVEL_W'(1): direct_val = root1_reg;
            qtw_pkg::LEVEL_W'(2): direct_val = root2_reg;
            qtw_pkg::LEVEL_W'(3): direct_val = root3_reg;
            default:              direct_val = ABSENT;
        endcase
    end

    // child selection
    logic          lat_bit, lng_bit;
    logic [NB-1:0] child;

    assign lat_bit = (sh_reg < qtw_pkg::LEVEL_W'(qtw_pkg::LAT_W)) ? lat_reg[sh_reg[3:0]] : 1'b0;
    assign lng_bit = (sh_reg < qtw_pkg::LEVEL_W'(qtw_pkg::LNG_W)) ? lng_reg[sh_reg] : 1'b0;

    always_comb begin
        case ({lat_bit, lng_bit})
            2'b00:   child = rd_data_reg[0*NB +: NB];
            2'b01:   child = rd_data_reg[1*NB +: NB];
            2'b10:   child = rd_data_reg[2*NB +: NB];
            default: child = rd_data_reg[3*NB +: NB];
        endcase
    end

    assign rd_en = cmd.walk_start || cmd.walk_step;
    assign rd_addr = cmd.walk_start ? root4 : child;

    // pending result and output register
    logic [NB-1:0] res_reg;
    logic          m_valid_reg, m_valid_next;
    logic [NB-1:0] out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_direct) begin
            res_reg <= direct_val;
        end else if (cmd.res_root) begin
            res_reg <= root4;
        end else if (cmd.res_child) begin
            res_reg <= child;
        end
        if (cmd.push) begin
            out_reg <= res_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_node_index = qtw_pkg::FIELD_W'(out_reg);
    assign m_found = (out_reg != ABSENT);

    assign status.direct = (lvl_reg <= LVL_ROOT3) || (lvl_reg > MAX_LVL);
    assign status.root_final = (lvl_reg == LVL_ROOT4) || (root4 == ABSENT);
    assign status.child_final = (sh_reg == '0) || (child == ABSENT);
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

/* rtl/quadtree_node_index_walk_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_node_index_walk_core: quadtree tile node lookup
// Stores quadtree nodes and walks from the level roots to the node of a tile.
// ----------------------------------------------------------------------------
//
//  channel  | ports                         | word
//  ---------+-------------------------------+--------------------------------
//  input    | s_valid / s_ready / s_*       | load entry or lookup request
//  result   | m_valid / m_ready / m_*       | node_index, found (lookups only)
//  config   | cfg_wen / cfg_index/cfg_wdata | root registers, one write/cycle
//
//  A load word leaves the sequencer idle; s_ready stays high after it.
//  A lookup at levels 0..4 and above MAX_LEVEL needs no table read; at deeper
//  levels it reads the table once per level below 4, each read depending on
//  the last, and s_ready stays low until its result enters the output register.
//  An absent level-4 root or child ends the walk early.
//  The result sits in an output register; the next word is taken while it waits.
//  Reset (aresetn, synchronous) clears roots to absent and empties the pipe;
//  the node table is not cleared and must be loaded before it is looked up.
//
module quadtree_node_index_walk_core #(
    parameter int NODE_BITS = 16,
    parameter int MAX_LEVEL = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wen,
    input  logic [qtw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qtw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [qtw_pkg::FIELD_W-1:0]     s_entry_index,
    input  logic [qtw_pkg::FIELD_W-1:0]     s_child_slot0,
    input  logic [qtw_pkg::FIELD_W-1:0]     s_child_slot1,
    input  logic [qtw_pkg::FIELD_W-1:0]     s_child_slot2,
    input  logic [qtw_pkg::FIELD_W-1:0]     s_child_slot3,
    input  logic [qtw_pkg::LEVEL_W-1:0]     s_level,
    input  logic [qtw_pkg::LAT_W-1:0]       s_lat_index,
    input  logic [qtw_pkg::LNG_W-1:0]       s_lng_index,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [qtw_pkg::FIELD_W-1:0]     m_node_index,
    output logic                            m_found
);

    qtw_pkg::cmd_t    cmd;
    qtw_pkg::status_t status;

    // sequencer: idle/decode/walk/done
    qtw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table, roots, per-level bit selection and output register
    qtw_datapath #(
        .NODE_BITS (NODE_BITS),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_mode        (s_mode),
        .s_entry_index (s_entry_index),
        .s_child_slot0 (s_child_slot0),
        .s_child_slot1 (s_child_slot1),
        .s_child_slot2 (s_child_slot2),
        .s_child_slot3 (s_child_slot3),
        .s_level       (s_level),
        .s_lat_index   (s_lat_index),
        .s_lng_index   (s_lng_index),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_node_index  (m_node_index),
        .m_found       (m_found),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

/* rtl/qtw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtw_checker: port-level checks for the quadtree node walk
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module qtw_checker #(
    parameter int NODE_BITS = 16
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_mode,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [qtw_pkg::FIELD_W-1:0] m_node_index,
    input logic                        m_found
);

    localparam logic [NODE_BITS-1:0] ABSENT = {NODE_BITS{1'b1}};
    localparam logic [qtw_pkg::FIELD_W-1:0] ABSENT_OUT = qtw_pkg::FIELD_W'(ABSENT);

    // a lookup keeps s_ready low after it is accepted
    a_lookup_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode) |=> !s_ready)
        else $error("s_ready high right after a lookup");

    // a load word never blocks the input
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_mode) |=> s_ready)
        else $error("s_ready dropped after a load");

    // not found implies the absent index
    a_absent_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_node_index == ABSENT_OUT))
        else $error("absent result with non-absent index");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_node_index) && $stable(m_found)))
        else $error("result changed while stalled");

endmodule

bind quadtree_node_index_walk_core qtw_checker #(
    .NODE_BITS (NODE_BITS)
) u_qtw_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_mode       (s_mode),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_node_index (m_node_index),
    .m_found      (m_found)
);
